### hdl/bsc_pkg.sv
// Shared types, codes and the control store for the safety-check sequencer.
// No dependencies; imported by bsc_useq and bsc_datapath.
package bsc_pkg;

   // request kinds (req_tuser)
   localparam logic [1:0] CMD_LOAD_PAIR  = 2'd0;
   localparam logic [1:0] CMD_LOAD_AVAIL = 2'd1;
   localparam logic [1:0] CMD_RUN        = 2'd2;

   // result kinds (rsp_tuser)
   localparam logic [1:0] ST_FIN    = 2'd0;
   localparam logic [1:0] ST_SAFE   = 2'd1;
   localparam logic [1:0] ST_UNSAFE = 2'd2;

   // config register indexes
   localparam logic CSR_PROCESS_COUNT  = 1'b0;
   localparam logic CSR_RES_TYPE_COUNT = 1'b1;

   localparam logic [16:0] AVAIL_MAX = 17'h1FFFF;

   // datapath ops
   localparam logic [3:0] OP_NOP        = 4'd0;
   localparam logic [3:0] OP_INIT       = 4'd1;
   localparam logic [3:0] OP_PASS       = 4'd2;
   localparam logic [3:0] OP_CHK0       = 4'd3;
   localparam logic [3:0] OP_CMP        = 4'd4;
   localparam logic [3:0] OP_R0         = 4'd5;
   localparam logic [3:0] OP_ADD        = 4'd6;
   localparam logic [3:0] OP_EMIT_FIN   = 4'd7;
   localparam logic [3:0] OP_PNEXT      = 4'd8;
   localparam logic [3:0] OP_EMIT_SAFE  = 4'd9;
   localparam logic [3:0] OP_EMIT_UNSAF = 4'd10;

   // branch conditions
   localparam logic [3:0] C_NEVER = 4'd0;
   localparam logic [3:0] C_RUN   = 4'd1;
   localparam logic [3:0] C_NP0   = 4'd2;
   localparam logic [3:0] C_PEND  = 4'd3;
   localparam logic [3:0] C_DONEP = 4'd4;
   localparam logic [3:0] C_REND  = 4'd5;
   localparam logic [3:0] C_FIT   = 4'd6;
   localparam logic [3:0] C_BUSY  = 4'd7;
   localparam logic [3:0] C_LEFT0 = 4'd8;
   localparam logic [3:0] C_PROG  = 4'd9;

   // microprogram steps
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_RUNI   = 4'd1;
   localparam logic [3:0] S_PASS   = 4'd2;
   localparam logic [3:0] S_PROC   = 4'd3;
   localparam logic [3:0] S_PCHK   = 4'd4;
   localparam logic [3:0] S_CRD    = 4'd5;
   localparam logic [3:0] S_CCMP   = 4'd6;
   localparam logic [3:0] S_CDEC   = 4'd7;
   localparam logic [3:0] S_ARD    = 4'd8;
   localparam logic [3:0] S_AADD   = 4'd9;
   localparam logic [3:0] S_EMIT   = 4'd10;
   localparam logic [3:0] S_NEXTP  = 4'd11;
   localparam logic [3:0] S_ENDP   = 4'd12;
   localparam logic [3:0] S_ENDP2  = 4'd13;
   localparam logic [3:0] S_SAFE   = 4'd14;
   localparam logic [3:0] S_UNSAFE = 4'd15;

   typedef struct packed {
      logic [3:0] op;
      logic [3:0] cond;
      logic [3:0] tgt_t;   // next step when cond holds
      logic [3:0] tgt_f;   // next step otherwise
   } ctl_word_type;

   typedef struct packed {
      logic       accept_en;
      logic [3:0] op;
   } dp_ctl_type;

   typedef struct packed {
      logic run_req;
      logic np_zero;
      logic p_end;
      logic done_p;
      logic r_end;
      logic fit;
      logic out_busy;
      logic left_zero;
      logic progress;
   } dp_flags_type;

   function automatic ctl_word_type ucode_rom(input logic [3:0] upc);
      ctl_word_type w;
      unique case (upc)
         S_IDLE:   w = '{OP_NOP,        C_RUN,   S_RUNI,   S_IDLE};
         S_RUNI:   w = '{OP_INIT,       C_NP0,   S_SAFE,   S_PASS};
         S_PASS:   w = '{OP_PASS,       C_NEVER, S_PASS,   S_PROC};
         S_PROC:   w = '{OP_NOP,        C_PEND,  S_ENDP,   S_PCHK};
         S_PCHK:   w = '{OP_CHK0,       C_DONEP, S_NEXTP,  S_CRD};
         S_CRD:    w = '{OP_NOP,        C_REND,  S_CDEC,   S_CCMP};
         S_CCMP:   w = '{OP_CMP,        C_NEVER, S_CCMP,   S_CRD};
         S_CDEC:   w = '{OP_R0,         C_FIT,   S_ARD,    S_NEXTP};
         S_ARD:    w = '{OP_NOP,        C_REND,  S_EMIT,   S_AADD};
         S_AADD:   w = '{OP_ADD,        C_NEVER, S_AADD,   S_ARD};
         S_EMIT:   w = '{OP_EMIT_FIN,   C_BUSY,  S_EMIT,   S_NEXTP};
         S_NEXTP:  w = '{OP_PNEXT,      C_NEVER, S_NEXTP,  S_PROC};
         S_ENDP:   w = '{OP_NOP,        C_LEFT0, S_SAFE,   S_ENDP2};
         S_ENDP2:  w = '{OP_NOP,        C_PROG,  S_PASS,   S_UNSAFE};
         S_SAFE:   w = '{OP_EMIT_SAFE,  C_BUSY,  S_SAFE,   S_IDLE};
         S_UNSAFE: w = '{OP_EMIT_UNSAF, C_BUSY,  S_UNSAFE, S_IDLE};
      endcase
      return w;
   endfunction

endpackage

### hdl/bankers_safety_check.sv
// Top level of the banker's-algorithm safety checker.
// Depends on bsc_pkg, bsc_useq, bsc_datapath (which holds bsc_ram).
//
//  channel  dir  handshake          payload
//  -------  ---  -----------------  ----------------------------------------------
//  req_*    in   tvalid / tready    tuser: cmd; tdata: proc, res, alloc, max, avail
//  rsp_*    out  tvalid / tready    tuser: status; tdata: proc, avail_0..7; tlast
//  csr_*    in   we (no stall)      index 0 process_count, 1 resource_type_count
//
// Load requests are accepted back to back while idle. A run request holds req_tready
// low until its final result is registered. After an init step, each pass skips
// finished processes, compares each need with the available count (a RAM read step,
// then a compare step per entry) and, if all fit, adds the allocations back (read and
// add steps per entry) and emits a finish result. With none left the run ends safe,
// else a pass that made progress repeats, else it ends unsafe. A stalled rsp_tready
// freezes the sequencer at its result step. Synchronous reset clears the process count,
// sets resource type count to 1 and clears available counts and flags; RAM is not cleared.
module bankers_safety_check #(
   parameter int MAX_PROCS = 16,
   parameter int MAX_RES   = 8
) (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,   // proc_index[3:0], res_index[6:4], alloc_value[18:7],
                                     // max_value[30:19], avail_value[42:31], zero fill
   input  logic [1:0]   req_tuser,   // cmd[1:0]
   // result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [143:0] rsp_tdata,   // finished_proc[3:0], avail_0[20:4], avail_1[37:21],
                                     // avail_2[54:38], avail_3[71:55], avail_4[88:72],
                                     // avail_5[105:89], avail_6[122:106],
                                     // avail_7[139:123], zero fill
   output logic [1:0]   rsp_tuser,   // status[1:0]
   output logic         rsp_tlast,
   // config write port
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [4:0]   csr_wdata
);
   import bsc_pkg::*;

   dp_ctl_type   ctl;
   dp_flags_type flags;

   // sequencer: step counter and control store
   bsc_useq u_useq (
      .clock      (clock),
      .reset      (reset),
      .flags      (flags),
      .ctl        (ctl),
      .req_tready (req_tready)
   );

   // datapath: stores, counters, comparator, saturating adder, result register
   bsc_datapath #(
      .MAX_PROCS (MAX_PROCS),
      .MAX_RES   (MAX_RES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .flags      (flags),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### hdl/bsc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bsc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hdl/bsc_useq.sv
// Microcode sequencer: step counter, control store lookup, two-way branch.
// Depends on bsc_pkg.
module bsc_useq (
   input  logic                  clock,
   input  logic                  reset,
   input  bsc_pkg::dp_flags_type flags,
   output bsc_pkg::dp_ctl_type   ctl,
   output logic                  req_tready
);
   import bsc_pkg::*;

   logic [3:0]   upc_ff;
   logic [3:0]   upc_in;
   ctl_word_type word;
   logic         cond_true;
   logic         stall;

   always_comb begin
      word = ucode_rom(upc_ff);
      case (word.cond)
         C_RUN:   cond_true = flags.run_req;
         C_NP0:   cond_true = flags.np_zero;
         C_PEND:  cond_true = flags.p_end;
         C_DONEP: cond_true = flags.done_p;
         C_REND:  cond_true = flags.r_end;
         C_FIT:   cond_true = flags.fit;
         C_BUSY:  cond_true = flags.out_busy;
         C_LEFT0: cond_true = flags.left_zero;
         C_PROG:  cond_true = flags.progress;
         default: cond_true = 1'b0;
      endcase
      // a busy output holds the step and suppresses its op
      stall  = (word.cond == C_BUSY) && cond_true;
      upc_in = cond_true ? word.tgt_t : word.tgt_f;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= S_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

   assign ctl.accept_en = (upc_ff == S_IDLE);
   assign ctl.op        = stall ? OP_NOP : word.op;
   assign req_tready    = (upc_ff == S_IDLE);

endmodule

### hdl/bsc_datapath.sv
// Datapath: config regs, alloc/max RAM, available vector, counters, result reg.
// Depends on bsc_pkg and bsc_ram.
module bsc_datapath #(
   parameter int MAX_PROCS = 16,
   parameter int MAX_RES   = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bsc_pkg::dp_ctl_type   ctl,
   output bsc_pkg::dp_flags_type flags,
   input  logic                  req_tvalid,
   input  logic [47:0]           req_tdata,
   input  logic [1:0]            req_tuser,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [4:0]            csr_wdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [143:0]          rsp_tdata,
   output logic [1:0]            rsp_tuser,
   output logic                  rsp_tlast
);
   import bsc_pkg::*;

   localparam int PW    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int RW    = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
   localparam int PCW   = $clog2(MAX_PROCS + 1);
   localparam int RCW   = $clog2(MAX_RES + 1);
   localparam int DEPTH = 1 << (PW + RW);

   // request fields
   logic [1:0]  f_cmd;
   logic [3:0]  f_proc;
   logic [2:0]  f_res;
   logic [11:0] f_alloc;
   logic [11:0] f_max;
   logic [11:0] f_avail;

   assign f_cmd   = req_tuser;
   assign f_proc  = req_tdata[3:0];
   assign f_res   = req_tdata[6:4];
   assign f_alloc = req_tdata[18:7];
   assign f_max   = req_tdata[30:19];
   assign f_avail = req_tdata[42:31];

   logic [4:0]           pcount_ff, pcount_in;
   logic [3:0]           rcount_ff, rcount_in;
   logic [PCW-1:0]       p_ff, p_in;
   logic [RCW-1:0]       r_ff, r_in;
   logic [PCW-1:0]       left_ff, left_in;
   logic                 fit_ff, fit_in;
   logic                 prog_ff, prog_in;
   logic [MAX_PROCS-1:0] done_ff, done_in;
   logic [16:0]          avail_ff [MAX_RES];
   logic [16:0]          avail_in [MAX_RES];
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [3:0]           rsp_proc_ff, rsp_proc_in;
   logic [7:0][16:0]     rsp_avail_ff, rsp_avail_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [PCW-1:0]       nproc;
   logic [RCW-1:0]       nres;
   logic [PW-1:0]        p_idx;
   logic [RW-1:0]        r_idx;
   logic [PW-1:0]        ld_p;
   logic [RW-1:0]        ld_r;
   logic                 p_ok;
   logic                 r_ok;
   logic                 load_go;
   logic                 ram_we;
   logic [23:0]          ram_rd;
   logic [11:0]          rd_alloc;
   logic [11:0]          rd_max;
   logic [16:0]          avail_cur;
   logic                 blocks;
   logic [17:0]          sum;
   logic [16:0]          sum_sat;
   logic                 out_busy;
   logic [7:0][16:0]     snap;

   // clamp oversized counts
   always_comb begin
      if (32'(pcount_ff) > MAX_PROCS) begin
         nproc = PCW'(MAX_PROCS);
      end else begin
         nproc = PCW'(pcount_ff);
      end
      if (32'(rcount_ff) > MAX_RES) begin
         nres = RCW'(MAX_RES);
      end else begin
         nres = RCW'(rcount_ff);
      end
   end

   assign p_idx   = p_ff[PW-1:0];
   assign r_idx   = r_ff[RW-1:0];
   assign ld_p    = PW'(f_proc);
   assign ld_r    = RW'(f_res);
   assign p_ok    = (32'(f_proc) < MAX_PROCS);
   assign r_ok    = (32'(f_res) < MAX_RES);
   assign load_go = ctl.accept_en && req_tvalid;
   assign ram_we  = load_go && (f_cmd == CMD_LOAD_PAIR) && p_ok && r_ok;

   // {max, alloc} per (process, resource)
   bsc_ram #(
      .WIDTH (24),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr ({ld_p, ld_r}),
      .wdata ({f_max, f_alloc}),
      .raddr ({p_idx, r_idx}),
      .rdata (ram_rd)
   );

   assign rd_alloc  = ram_rd[11:0];
   assign rd_max    = ram_rd[23:12];
   assign avail_cur = avail_ff[r_idx];
   assign blocks    = (rd_max > rd_alloc) && ({5'b0, rd_max - rd_alloc} > avail_cur);
   assign sum       = {1'b0, avail_cur} + {6'b0, rd_alloc};
   assign sum_sat   = sum[17] ? AVAIL_MAX : sum[16:0];
   assign out_busy  = rsp_valid_ff && !rsp_tready;

   for (genvar j = 0; j < 8; j++) begin : g_snap
      if (j < MAX_RES) begin : g_used
         assign snap[j] = avail_ff[j];
      end else begin : g_zero
         assign snap[j] = '0;
      end
   end

   always_comb begin
      pcount_in     = pcount_ff;
      rcount_in     = rcount_ff;
      p_in          = p_ff;
      r_in          = r_ff;
      left_in       = left_ff;
      fit_in        = fit_ff;
      prog_in       = prog_ff;
      done_in       = done_ff;
      avail_in      = avail_ff;
      rsp_valid_in  = out_busy;
      rsp_status_in = rsp_status_ff;
      rsp_proc_in   = rsp_proc_ff;
      rsp_avail_in  = rsp_avail_ff;
      rsp_last_in   = rsp_last_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_PROCESS_COUNT:  pcount_in = csr_wdata;
            CSR_RES_TYPE_COUNT: rcount_in = csr_wdata[3:0];
         endcase
      end

      if (load_go && (f_cmd == CMD_LOAD_AVAIL) && r_ok) begin
         avail_in[ld_r] = {5'b0, f_avail};
      end

      case (ctl.op)
         OP_INIT: begin
            done_in = '0;
            left_in = nproc;
         end
         OP_PASS: begin
            p_in    = '0;
            prog_in = 1'b0;
         end
         OP_CHK0: begin
            r_in   = '0;
            fit_in = 1'b1;
         end
         OP_CMP: begin
            if (blocks) begin
               fit_in = 1'b0;
            end
            r_in = r_ff + 1'b1;
         end
         OP_R0: begin
            r_in = '0;
         end
         OP_ADD: begin
            avail_in[r_idx] = sum_sat;
            r_in            = r_ff + 1'b1;
         end
         OP_EMIT_FIN: begin
            done_in[p_idx] = 1'b1;
            prog_in        = 1'b1;
            left_in        = left_ff - 1'b1;
            rsp_valid_in   = 1'b1;
            rsp_status_in  = ST_FIN;
            rsp_proc_in    = 4'(p_ff);
            rsp_avail_in   = snap;
            rsp_last_in    = 1'b0;
         end
         OP_PNEXT: begin
            p_in = p_ff + 1'b1;
         end
         OP_EMIT_SAFE: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_SAFE;
            rsp_proc_in   = '0;
            rsp_avail_in  = snap;
            rsp_last_in   = 1'b1;
         end
         OP_EMIT_UNSAF: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_UNSAFE;
            rsp_proc_in   = '0;
            rsp_avail_in  = snap;
            rsp_last_in   = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pcount_ff    <= '0;
         rcount_ff    <= 4'd1;
         p_ff         <= '0;
         r_ff         <= '0;
         left_ff      <= '0;
         fit_ff       <= 1'b0;
         prog_ff      <= 1'b0;
         done_ff      <= '0;
         for (int i = 0; i < MAX_RES; i++) begin
            avail_ff[i] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         pcount_ff    <= pcount_in;
         rcount_ff    <= rcount_in;
         p_ff         <= p_in;
         r_ff         <= r_in;
         left_ff      <= left_in;
         fit_ff       <= fit_in;
         prog_ff      <= prog_in;
         done_ff      <= done_in;
         avail_ff     <= avail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_proc_ff   <= rsp_proc_in;
      rsp_avail_ff  <= rsp_avail_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign flags.run_req   = req_tvalid && (f_cmd == CMD_RUN);
   assign flags.np_zero   = (nproc == '0);
   assign flags.p_end     = (p_ff == nproc);
   assign flags.done_p    = done_ff[p_idx];
   assign flags.r_end     = (r_ff == nres);
   assign flags.fit       = fit_ff;
   assign flags.out_busy  = out_busy;
   assign flags.left_zero = (left_ff == '0);
   assign flags.progress  = prog_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {4'b0, rsp_avail_ff, rsp_proc_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_fin_undone: assert property (@(posedge clock) disable iff (reset)
      (ctl.op == OP_EMIT_FIN) |-> (!done_ff[p_idx] && (p_ff < nproc) && (left_ff != '0)))
      else $error("finish reported for a finished or absent process");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      ((ctl.op == OP_EMIT_FIN) || (ctl.op == OP_EMIT_SAFE) || (ctl.op == OP_EMIT_UNSAF))
      |-> !out_busy)
      else $error("result overwritten while held");
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_last_ff == (rsp_status_ff != ST_FIN)))
      else $error("last flag does not match result kind");
   a_one_emit: assert property (@(posedge clock) disable iff (reset)
      (ctl.op == OP_EMIT_FIN) |=> (ctl.op != OP_EMIT_FIN))
      else $error("two finish results back to back");
`endif

endmodule
